@@ sv/lpg_pkg.sv @@
// Package for the line pixel generator: item kinds, step sign codes, the
// setup and pixel structs, and the coordinate clamp shared by lpg_setup and lpg_stepper.
// No dependencies.
`default_nettype none

package lpg_pkg;

   // Item kinds carried on req_tuser.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Two-bit signed step codes.
   localparam logic [1:0] STEP_NEG  = 2'b11;
   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;

   localparam int COL_W   = 10;
   localparam int ROW_W   = 9;
   localparam int ADDR_W  = 19;
   localparam int COLOR_W = 16;
   localparam int ERR_W   = 12;
   localparam int COORD_W = 11;

   // Everything a load item sets up for the stepping engine.
   typedef struct packed {
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic [9:0]              major_delta;
      logic [9:0]              minor_delta;
      logic signed [ERR_W-1:0] err_term;
      logic [1:0]              col_step;
      logic [1:0]              row_step;
      logic                    axes_swapped;
   } line_setup_type;

   // One emitted pixel.
   typedef struct packed {
      logic                  last;
      logic [COLOR_W-1:0]    pix_color;
      logic [ADDR_W-1:0]     pix_addr;
      logic [ROW_W-1:0]      pix_y;
      logic [COL_W-1:0]      pix_x;
   } pixel_type;

   // Clamps a signed coordinate to 0..limit-1; limit is at most 1024.
   function automatic logic [9:0] clamp_coord(input logic signed [11:0] v,
                                              input logic [10:0] limit);
      logic signed [11:0] top;
      top = $signed({1'b0, limit}) - 12'sd1;
      if (v > top) begin
         return top[9:0];
      end else if (v < 12'sd0) begin
         return 10'd0;
      end else begin
         return v[9:0];
      end
   endfunction

endpackage

`default_nettype wire

@@ sv/lpg_setup.sv @@
// Line setup: clamps both endpoints to the screen and derives deltas, step
// signs, axis swap and the initial error term. Uses lpg_pkg.
`default_nettype none

module lpg_setup #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  wire logic signed [10:0] start_x,
   input  wire logic signed [10:0] start_y,
   input  wire logic signed [10:0] end_x,
   input  wire logic signed [10:0] end_y,
   output lpg_pkg::line_setup_type setup
);

   localparam logic [10:0] WIDTH_LIM  = 11'(SCREEN_WIDTH);
   localparam logic [10:0] HEIGHT_LIM = 11'(SCREEN_HEIGHT);

   logic [9:0]  x1;
   logic [9:0]  y1;
   logic [9:0]  x2;
   logic [9:0]  y2;
   logic [9:0]  dx;
   logic [9:0]  dy;
   logic [1:0]  sx;
   logic [1:0]  sy;
   logic        swap;
   logic [9:0]  major;
   logic [9:0]  minor;
   logic signed [12:0] err_wide;

   always_comb begin
      x1 = lpg_pkg::clamp_coord({start_x[10], start_x}, WIDTH_LIM);
      y1 = lpg_pkg::clamp_coord({start_y[10], start_y}, HEIGHT_LIM);
      x2 = lpg_pkg::clamp_coord({end_x[10], end_x}, WIDTH_LIM);
      y2 = lpg_pkg::clamp_coord({end_y[10], end_y}, HEIGHT_LIM);

      if (x2 < x1) begin
         dx = x1 - x2;
         sx = lpg_pkg::STEP_NEG;
      end else if (x2 == x1) begin
         dx = 10'd0;
         sx = lpg_pkg::STEP_ZERO;
      end else begin
         dx = x2 - x1;
         sx = lpg_pkg::STEP_POS;
      end

      if (y2 < y1) begin
         dy = y1 - y2;
         sy = lpg_pkg::STEP_NEG;
      end else if (y2 == y1) begin
         dy = 10'd0;
         sy = lpg_pkg::STEP_ZERO;
      end else begin
         dy = y2 - y1;
         sy = lpg_pkg::STEP_POS;
      end

      swap  = dy > dx;
      major = swap ? dy : dx;
      minor = swap ? dx : dy;
      err_wide = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});

      setup.col          = x1;
      setup.row          = y1[8:0];
      setup.major_delta  = major;
      setup.minor_delta  = minor;
      setup.err_term     = err_wide[11:0];
      setup.col_step     = sx;
      setup.row_step     = sy;
      setup.axes_swapped = swap;
   end

endmodule

`default_nettype wire

@@ sv/lpg_stepper.sv @@
// Stepping engine: holds the running line state, emits the current pixel and
// advances one Bresenham step per step item while a line is active. Uses lpg_pkg.
`default_nettype none

module lpg_stepper #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load_en,
   input  wire logic                   step_en,
   input  wire lpg_pkg::line_setup_type setup,
   input  wire logic [15:0]            line_color,
   output logic                        pix_valid,
   output lpg_pkg::pixel_type          pixel
);

   localparam logic [10:0] WIDTH_LIM  = 11'(SCREEN_WIDTH);
   localparam logic [10:0] HEIGHT_LIM = 11'(SCREEN_HEIGHT);
   localparam logic [9:0]  WIDTH_MUL  = 10'(SCREEN_WIDTH);

   logic               active_ff, active_in;
   logic [9:0]         col_ff, col_in;
   logic [8:0]         row_ff, row_in;
   logic signed [11:0] err_ff, err_in;
   logic [9:0]         major_ff, major_in;
   logic [9:0]         minor_ff, minor_in;
   logic [9:0]         left_ff, left_in;
   logic [1:0]         cstep_ff, cstep_in;
   logic [1:0]         rstep_ff, rstep_in;
   logic               swap_ff, swap_in;
   logic [15:0]        color_ff, color_in;

   logic               is_last;
   logic               err_pos;
   logic signed [11:0] c_next;
   logic signed [11:0] r_next;
   logic signed [11:0] c_inc;
   logic signed [11:0] r_inc;
   logic signed [12:0] err_next;
   logic [18:0]        row_prod;
   logic [19:0]        addr_sum;

   always_comb begin
      is_last = left_ff <= 10'd1;
      err_pos = !err_ff[11];

      // Minor axis moves only when the error term is non-negative.
      c_inc = {{10{cstep_ff[1]}}, cstep_ff};
      r_inc = {{10{rstep_ff[1]}}, rstep_ff};
      if (swap_ff && !err_pos) begin
         c_inc = 12'sd0;
      end
      if (!swap_ff && !err_pos) begin
         r_inc = 12'sd0;
      end
      c_next = $signed({2'b00, col_ff}) + c_inc;
      r_next = $signed({3'b000, row_ff}) + r_inc;

      err_next = $signed({err_ff[11], err_ff}) + $signed({2'b00, minor_ff, 1'b0});
      if (err_pos) begin
         err_next = err_next - $signed({2'b00, major_ff, 1'b0});
      end

      row_prod = row_ff * WIDTH_MUL;
      addr_sum = {1'b0, row_prod} + {10'd0, col_ff};

      pix_valid       = step_en && active_ff;
      pixel.pix_x     = col_ff;
      pixel.pix_y     = row_ff;
      pixel.pix_addr  = addr_sum[18:0];
      pixel.pix_color = color_ff;
      pixel.last      = is_last;

      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      err_in    = err_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      left_in   = left_ff;
      cstep_in  = cstep_ff;
      rstep_in  = rstep_ff;
      swap_in   = swap_ff;
      color_in  = color_ff;

      if (load_en) begin
         active_in = 1'b1;
         col_in    = setup.col;
         row_in    = setup.row;
         err_in    = setup.err_term;
         major_in  = setup.major_delta;
         minor_in  = setup.minor_delta;
         left_in   = setup.major_delta + 10'd1;
         cstep_in  = setup.col_step;
         rstep_in  = setup.row_step;
         swap_in   = setup.axes_swapped;
         color_in  = line_color;
      end else if (pix_valid) begin
         col_in = lpg_pkg::clamp_coord(c_next, WIDTH_LIM);
         row_in = 9'(lpg_pkg::clamp_coord(r_next, HEIGHT_LIM));
         err_in = err_next[11:0];
         if (is_last) begin
            left_in   = 10'd0;
            active_in = 1'b0;
         end else begin
            left_in = left_ff - 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         err_ff    <= '0;
         major_ff  <= '0;
         minor_ff  <= '0;
         left_ff   <= '0;
         cstep_ff  <= '0;
         rstep_ff  <= '0;
         swap_ff   <= 1'b0;
         color_ff  <= '0;
      end else begin
         active_ff <= active_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         err_ff    <= err_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         left_ff   <= left_in;
         cstep_ff  <= cstep_in;
         rstep_ff  <= rstep_in;
         swap_ff   <= swap_in;
         color_ff  <= color_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/lpg_out_stage.sv @@
// Result register with a skid entry, so a pixel produced while the output is
// stalled is held rather than lost. Uses lpg_pkg.
`default_nettype none

module lpg_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire lpg_pkg::pixel_type in_pixel,
   output logic                    in_ready,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output lpg_pkg::pixel_type      out_pixel
);

   logic               out_valid_ff, out_valid_in;
   lpg_pkg::pixel_type out_pixel_ff, out_pixel_in;
   logic               skid_valid_ff, skid_valid_in;
   lpg_pkg::pixel_type skid_pixel_ff, skid_pixel_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_pixel_in  = out_pixel_ff;
      skid_valid_in = skid_valid_ff;
      skid_pixel_in = skid_pixel_ff;

      // New items are taken only while the skid entry is empty.
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_pixel_in  = skid_pixel_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_pixel_in = in_pixel;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_pixel_in = in_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_pixel_ff  <= out_pixel_in;
      skid_pixel_ff <= skid_pixel_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;

endmodule

`default_nettype wire

@@ sv/line_pixel_generator.sv @@
// Line pixel generator top level: Bresenham line rasterizer with a stream
// input and a stream pixel output. Uses lpg_pkg, lpg_setup, lpg_stepper and
// lpg_out_stage.
//
// A load item (tuser = 0) takes two endpoints and a color and
// gives no pixel; endpoints are clamped to the screen. Each step item
// (tuser = 1) gives the next pixel of the line with its column, row,
// frame-buffer index (row * SCREEN_WIDTH + column) and color; tlast marks the
// final pixel. A line of major-axis length d gives d + 1 pixels. Step items
// while no line is running are taken and dropped. The line state registers
// advance once per accepted step of a running line, and the pixel goes
// through a result register with one skid entry, so an item is accepted in
// every cycle as long as the consumer keeps up.
`default_nettype none

module line_pixel_generator #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33],
   // line_color[59:44], zero[63:60]
   input  wire logic [63:0] req_tdata,
   // op[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pix_x[9:0], pix_y[18:10], pix_addr[37:19], pix_color[53:38], zero[55:54]
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic                    accept;
   logic                    load_en;
   logic                    step_en;
   lpg_pkg::line_setup_type setup;
   logic                    pix_valid;
   lpg_pkg::pixel_type      pixel;
   lpg_pkg::pixel_type      out_pixel;

   assign accept  = req_tvalid && req_tready;
   assign load_en = accept && (req_tuser == lpg_pkg::OP_LOAD);
   assign step_en = accept && (req_tuser == lpg_pkg::OP_STEP);

   lpg_setup #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_setup (
      .start_x (req_tdata[10:0]),
      .start_y (req_tdata[21:11]),
      .end_x   (req_tdata[32:22]),
      .end_y   (req_tdata[43:33]),
      .setup   (setup)
   );

   lpg_stepper #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .step_en    (step_en),
      .setup      (setup),
      .line_color (req_tdata[59:44]),
      .pix_valid  (pix_valid),
      .pixel      (pixel)
   );

   lpg_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pix_valid),
      .in_pixel  (pixel),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (out_pixel)
   );

   assign rsp_tdata = {2'b00, out_pixel.pix_color, out_pixel.pix_addr,
                       out_pixel.pix_y, out_pixel.pix_x};
   assign rsp_tlast = out_pixel.last;

endmodule

`default_nettype wire

@@ sv/lpg_checker.sv @@
// Port-level checks for the line pixel generator, attached to the top level
// by the bind statement at the end. Uses lpg_pkg.
`default_nettype none

module lpg_checker #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   localparam logic [9:0] WIDTH_C  = 10'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_C = 9'(SCREEN_HEIGHT);

   logic [19:0] expect_addr;
   assign expect_addr = rsp_tdata[18:10] * WIDTH_C + {10'd0, rsp_tdata[9:0]};

   // No pixel appears straight out of reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("pixel valid right after reset");

   // A load never produces a pixel on its own.
   a_load_no_pixel: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == lpg_pkg::OP_LOAD) &&
      (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("pixel appeared after a load");

   // Emitted pixels lie on the screen.
   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:0] < WIDTH_C) && (rsp_tdata[18:10] < HEIGHT_C))
      else $error("pixel off screen");

   // The frame-buffer index agrees with the column and row.
   a_addr_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:19] == expect_addr[18:0])
      else $error("pixel address does not match coordinates");

   // A stalled pixel holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled pixel changed");

endmodule

bind line_pixel_generator lpg_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_lpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
